// File: rtl/crrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrc_pkg: shared types and constants for the redirect rule classifier
// Rule layout, search token, action and register codes.
// ----------------------------------------------------------------------------
package crrc_pkg;

  localparam int MAX_RULES = 256;
  localparam int SLOT_W    = 8;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int CFG_AW    = 5;

  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;

  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_PERMIT = 2'd1,
    ACT_BLOCK  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_PROXY_ADDR   = 3'd0,
    REG_PROXY_PORT   = 3'd1,
    REG_PROXY_PROC   = 3'd2,
    REG_FAIL_CLOSED  = 3'd3,
    REG_ACTIVE_RULES = 3'd4,
    REG_REDIRECT_EN  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] address;
    logic [15:0] port;
  } rule_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    rule_t             rule;
  } rule_wr_t;

  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] match_addr;
  } probe_t;

endpackage

// File: rtl/crrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrc_if: item channels of the redirect rule classifier
// Input channel (rule writes and classify requests) and verdict channel.
// ----------------------------------------------------------------------------
interface crrc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  rule_slot;
  logic [7:0]  protocol;
  logic [31:0] address;
  logic [15:0] port;
  logic [31:0] origin_process;
  logic        write_right;
  logic        already_redirected;
  logic        redirect_possible;

  modport source (
    output valid, func, rule_slot, protocol, address, port, origin_process,
           write_right, already_redirected, redirect_possible,
    input  ready
  );
  modport sink (
    input  valid, func, rule_slot, protocol, address, port, origin_process,
           write_right, already_redirected, redirect_possible,
    output ready
  );
endinterface

interface crrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        redirected;
  logic [31:0] new_address;
  logic [15:0] new_port;
  logic [31:0] target_process;
  logic [31:0] original_address;
  logic [15:0] original_port;
  logic [7:0]  original_protocol;
  logic [31:0] original_process;

  modport source (
    output valid, action, redirected, new_address, new_port, target_process,
           original_address, original_port, original_protocol, original_process,
    input  ready
  );
  modport sink (
    input  valid, action, redirected, new_address, new_port, target_process,
           original_address, original_port, original_protocol, original_process,
    output ready
  );
endinterface

// File: rtl/crrc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrc_cell: one rule slot of the search chain
// Holds one rule and marks the first hit on the probe passing through.
// ----------------------------------------------------------------------------
module crrc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [crrc_pkg::CNT_W-1:0]  cell_idx,
  input  logic [crrc_pkg::CNT_W-1:0]  limit,
  input  crrc_pkg::rule_wr_t          wr,
  input  crrc_pkg::rule_t             key,
  input  crrc_pkg::probe_t            probe_in,
  output crrc_pkg::probe_t            probe_out
);
  import crrc_pkg::*;

  localparam int CMP_W = SLOT_W + CNT_W;

  rule_t  rule_r;
  probe_t probe_r;
  probe_t probe_nxt;
  logic   hit;

  always_ff @(posedge clk) begin
    if (wr.en && (CMP_W'(wr.slot) == CMP_W'(cell_idx))) begin
      rule_r <= wr.rule;
    end
  end

  assign hit = (cell_idx < limit) &&
               (rule_r.protocol == key.protocol) &&
               (rule_r.address == key.address) &&
               ((rule_r.port == 16'd0) || (rule_r.port == key.port));

  always_comb begin
    probe_nxt = probe_in;
    // first hit wins: later cells leave an earlier match alone
    if (probe_in.valid && !probe_in.found && hit) begin
      probe_nxt.found      = 1'b1;
      probe_nxt.match_addr = rule_r.address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_out = probe_r;

endmodule

// File: rtl/connection_redirect_rule_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_redirect_rule_classifier_top: first-match redirect classifier
//
//   channel   direction  handshake        carries
//   in_bus    in         valid/ready      rule write or classify request
//   out_bus   out        valid/ready      verdict, one per classify beat
//   cfg_*     in         APB write/read   proxy target and search control
//
// A rule write beat lands in its slot at acceptance.
// A classify beat walks a probe through MAX_RULES rule cells, one per cycle;
// the verdict is registered once the probe leaves the last cell and out_bus is free.
// One item is in flight at a time; in_bus.ready stays low until the verdict
// is loaded, and a verdict still waiting on out_bus holds the next one back.
// Reset clears control state only; rule slots are undefined until written.
// ----------------------------------------------------------------------------
module connection_redirect_rule_classifier_top (
  input  logic                          clk,
  input  logic                          rst_n,
  crrc_in_if.sink                       in_bus,
  crrc_out_if.source                    out_bus,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [crrc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import crrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] proxy_addr_r;
  logic [15:0] proxy_port_r;
  logic [31:0] proxy_proc_r;
  logic        fail_closed_r;
  logic [8:0]  active_rules_r;
  logic        redirect_en_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // request held during the search
  rule_t       key_r;
  logic [31:0] origin_r;
  logic        wright_r;
  logic        already_r;
  logic        possible_r;
  logic        inject_r;
  logic        found_r;
  logic [31:0] match_r;

  // verdict register
  logic        out_valid_r;
  logic [1:0]  action_r;
  logic        redirected_r;
  logic [31:0] new_addr_r;
  logic [15:0] new_port_r;
  logic [31:0] target_proc_r;
  logic [31:0] orig_addr_r;
  logic [15:0] orig_port_r;
  logic [7:0]  orig_proto_r;
  logic [31:0] orig_proc_r;

  logic        in_acc;
  logic        load_out;
  logic [CNT_W-1:0] limit;
  rule_wr_t    wr;
  probe_t      probe [MAX_RULES+1];
  logic        bypass;

  assign in_acc = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE);

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proxy_addr_r   <= '0;
      proxy_port_r   <= '0;
      proxy_proc_r   <= '0;
      fail_closed_r  <= 1'b0;
      active_rules_r <= '0;
      redirect_en_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROXY_ADDR:   proxy_addr_r   <= cfg_pwdata;
        REG_PROXY_PORT:   proxy_port_r   <= cfg_pwdata[15:0];
        REG_PROXY_PROC:   proxy_proc_r   <= cfg_pwdata;
        REG_FAIL_CLOSED:  fail_closed_r  <= cfg_pwdata[0];
        REG_ACTIVE_RULES: active_rules_r <= cfg_pwdata[8:0];
        REG_REDIRECT_EN:  redirect_en_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROXY_ADDR:   cfg_prdata = proxy_addr_r;
      REG_PROXY_PORT:   cfg_prdata = {16'd0, proxy_port_r};
      REG_PROXY_PROC:   cfg_prdata = proxy_proc_r;
      REG_FAIL_CLOSED:  cfg_prdata = {31'd0, fail_closed_r};
      REG_ACTIVE_RULES: cfg_prdata = {23'd0, active_rules_r};
      REG_REDIRECT_EN:  cfg_prdata = {31'd0, redirect_en_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // saturate the searched count at the table size
  assign limit = (32'(active_rules_r) > 32'(MAX_RULES)) ? CNT_W'(MAX_RULES)
                                                        : CNT_W'(active_rules_r);

  // ------------------------------------------------------------ rule chain
  always_comb begin
    wr.en        = in_acc && (in_bus.func == FUNC_WRITE);
    wr.slot      = in_bus.rule_slot;
    wr.rule      = '{protocol: in_bus.protocol, address: in_bus.address,
                     port: in_bus.port};
  end

  assign probe[0] = '{valid: inject_r, found: 1'b0, match_addr: 32'd0};

  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    crrc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (CNT_W'(g)),
      .limit     (limit),
      .wr        (wr),
      .key       (key_r),
      .probe_in  (probe[g]),
      .probe_out (probe[g+1])
    );
  end

  // ----------------------------------------------------------- request hold
  always_ff @(posedge clk) begin
    if (in_acc && (in_bus.func == FUNC_CLASSIFY)) begin
      key_r      <= '{protocol: in_bus.protocol, address: in_bus.address,
                      port: in_bus.port};
      origin_r   <= in_bus.origin_process;
      wright_r   <= in_bus.write_right;
      already_r  <= in_bus.already_redirected;
      possible_r <= in_bus.redirect_possible;
    end
    if (probe[MAX_RULES].valid) begin
      found_r <= probe[MAX_RULES].found;
      match_r <= probe[MAX_RULES].match_addr;
    end
  end

  // --------------------------------------------------------------- control
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_bus.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_bus.func == FUNC_CLASSIFY)) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (probe[MAX_RULES].valid) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inject_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inject_r <= in_acc && (in_bus.func == FUNC_CLASSIFY);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- verdict
  assign bypass = !redirect_en_r || (key_r.protocol != PROTO_TCP) ||
                  (key_r.address == LOOPBACK_ADDR) || already_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      action_r      <= ACT_NONE;
      redirected_r  <= 1'b0;
      new_addr_r    <= '0;
      new_port_r    <= '0;
      target_proc_r <= '0;
      orig_addr_r   <= '0;
      orig_port_r   <= '0;
      orig_proto_r  <= '0;
      orig_proc_r   <= '0;
      if (wright_r) begin
        action_r <= ACT_PERMIT;
        if (!bypass && found_r) begin
          if (!possible_r) begin
            action_r <= fail_closed_r ? ACT_BLOCK : ACT_PERMIT;
          end else begin
            redirected_r  <= 1'b1;
            new_addr_r    <= proxy_addr_r;
            new_port_r    <= proxy_port_r;
            target_proc_r <= proxy_proc_r;
            orig_addr_r   <= match_r;
            orig_port_r   <= key_r.port;
            orig_proto_r  <= key_r.protocol;
            orig_proc_r   <= origin_r;
          end
        end
      end
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.action            = action_r;
  assign out_bus.redirected        = redirected_r;
  assign out_bus.new_address       = new_addr_r;
  assign out_bus.new_port          = new_port_r;
  assign out_bus.target_process    = target_proc_r;
  assign out_bus.original_address  = orig_addr_r;
  assign out_bus.original_port     = orig_port_r;
  assign out_bus.original_protocol = orig_proto_r;
  assign out_bus.original_process  = orig_proc_r;

endmodule

// File: rtl/crrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrc_checker: port-level checks for the redirect rule classifier
// Verdict consistency, busy behavior and output hold under backpressure.
// ----------------------------------------------------------------------------
module crrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_action,
  input logic        out_redirected,
  input logic [31:0] out_new_address,
  input logic [15:0] out_new_port,
  input logic [31:0] out_target_process,
  input logic [31:0] out_original_address,
  input logic [15:0] out_original_port,
  input logic [7:0]  out_original_protocol,
  input logic [31:0] out_original_process
);
  import crrc_pkg::*;

  // a stalled verdict beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
      $stable(out_redirected) && $stable(out_original_address))
    else $error("verdict changed while stalled");

  // a redirect is always a permit
  a_redir_permit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_redirected |-> out_action == ACT_PERMIT)
    else $error("redirect without permit");

  // without a redirect every address field reads zero
  a_no_redir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_redirected |-> out_new_address == 32'd0 &&
      out_new_port == 16'd0 && out_target_process == 32'd0 &&
      out_original_address == 32'd0 && out_original_port == 16'd0 &&
      out_original_protocol == 8'd0 && out_original_process == 32'd0)
    else $error("nonzero redirect fields on a plain verdict");

  // a classify beat occupies the block for the search
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_CLASSIFY) |=> !in_ready)
    else $error("new beat taken during a search");

endmodule

bind connection_redirect_rule_classifier_top crrc_checker u_crrc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_bus.valid),
  .in_ready              (in_bus.ready),
  .in_func               (in_bus.func),
  .out_valid             (out_bus.valid),
  .out_ready             (out_bus.ready),
  .out_action            (out_bus.action),
  .out_redirected        (out_bus.redirected),
  .out_new_address       (out_bus.new_address),
  .out_new_port          (out_bus.new_port),
  .out_target_process    (out_bus.target_process),
  .out_original_address  (out_bus.original_address),
  .out_original_port     (out_bus.original_port),
  .out_original_protocol (out_bus.original_protocol),
  .out_original_process  (out_bus.original_process)
);

// File: bench/connection_redirect_rule_classifier_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_redirect_rule_classifier_top_test: self-checking bench
// Loads the whole rule table, runs directed classify beats under several
// register settings, then random phases of rule writes and connection
// tuples. A bench-side first-match search predicts each verdict, and
// every verdict beat is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module connection_redirect_rule_classifier_top_test;
  import crrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int          PHASE_ITEMS  = 145;

  typedef struct packed {
    logic        func;
    logic [7:0]  rule_slot;
    logic [7:0]  protocol;
    logic [31:0] address;
    logic [15:0] port;
    logic [31:0] origin_process;
    logic        write_right;
    logic        already_redirected;
    logic        redirect_possible;
  } conn_item_t;

  typedef struct packed {
    action_t     action;
    logic        redirected;
    logic [31:0] new_address;
    logic [15:0] new_port;
    logic [31:0] target_process;
    logic [31:0] original_address;
    logic [15:0] original_port;
    logic [7:0]  original_protocol;
    logic [31:0] original_process;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  crrc_in_if  in_bus ();
  crrc_out_if out_bus ();

  connection_redirect_rule_classifier_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // bench copy of the block's registers and rule table
  logic [31:0] sh_proxy_addr;
  logic [15:0] sh_proxy_port;
  logic [31:0] sh_proxy_proc;
  logic        sh_fail_closed;
  logic [8:0]  sh_active_rules;
  logic        sh_redirect_en;
  rule_t       rule_row [MAX_RULES];

  conn_item_t  beats_pending [$];
  verdict_t    verdicts_due [$];
  conn_item_t  cur_beat;

  logic [31:0] addr_pool [8];
  logic [15:0] port_pool [6];

  bit          no_idle;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned cycles;
  int unsigned errors;
  int unsigned n_writes, n_classify, n_redirect, n_block, n_permit, n_none;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts still due", cycles,
               verdicts_due.size());
      $display("[connection_redirect_rule_classifier_top] ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  function automatic conn_item_t make_item(logic f, logic [7:0] slot, logic [7:0] proto,
                                           logic [31:0] addr, logic [15:0] prt,
                                           logic [31:0] origin, logic wr, logic already,
                                           logic possible);
    conn_item_t c;
    c.func               = f;
    c.rule_slot          = slot;
    c.protocol           = proto;
    c.address            = addr;
    c.port               = prt;
    c.origin_process     = origin;
    c.write_right        = wr;
    c.already_redirected = already;
    c.redirect_possible  = possible;
    return c;
  endfunction

  function automatic conn_item_t random_rule_write(logic [7:0] slot);
    logic [7:0]  proto;
    logic [31:0] addr;
    logic [15:0] prt;
    int unsigned r;
    proto = ($urandom_range(0, 99) < 80) ? PROTO_TCP : 8'($urandom);
    addr  = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, 7)] : $urandom;
    r = $urandom_range(0, 99);
    if (r < 40)      prt = 16'd0;
    else if (r < 80) prt = port_pool[$urandom_range(0, 5)];
    else             prt = 16'($urandom);
    return make_item(FUNC_WRITE, slot, proto, addr, prt, $urandom, 1'($urandom),
                     1'($urandom), 1'($urandom));
  endfunction

  function automatic conn_item_t random_conn();
    logic [7:0]  proto;
    logic [31:0] addr;
    logic [31:0] origin;
    int unsigned r;
    proto = ($urandom_range(0, 99) < 90) ? PROTO_TCP : 8'($urandom);
    addr  = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, 7)] : $urandom;
    r = $urandom_range(0, 19);
    origin = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    return make_item(FUNC_CLASSIFY, 8'($urandom), proto, addr,
                     ($urandom_range(0, 99) < 75) ? port_pool[$urandom_range(0, 5)]
                                                  : 16'($urandom),
                     origin, $urandom_range(0, 99) < 95, $urandom_range(0, 99) < 10,
                     $urandom_range(0, 99) < 80);
  endfunction

  // first-match search over the bench copy of the table
  function automatic verdict_t classify_conn(conn_item_t c);
    verdict_t v;
    int       lim;
    int       hit;
    int       i;
    v.action            = ACT_NONE;
    v.redirected        = 1'b0;
    v.new_address       = '0;
    v.new_port          = '0;
    v.target_process    = '0;
    v.original_address  = '0;
    v.original_port     = '0;
    v.original_protocol = '0;
    v.original_process  = '0;
    if (!c.write_right) return v;
    v.action = ACT_PERMIT;
    if (!sh_redirect_en || c.protocol != PROTO_TCP || c.address == LOOPBACK_ADDR ||
        c.already_redirected)
      return v;
    lim = (sh_active_rules > MAX_RULES) ? MAX_RULES : int'(sh_active_rules);
    hit = -1;
    for (i = 0; i < lim; i++) begin
      if (hit < 0 && rule_row[i].protocol == c.protocol && rule_row[i].address == c.address &&
          (rule_row[i].port == 16'd0 || rule_row[i].port == c.port))
        hit = i;
    end
    if (hit < 0) return v;
    if (!c.redirect_possible) begin
      v.action = sh_fail_closed ? ACT_BLOCK : ACT_PERMIT;
      return v;
    end
    v.redirected        = 1'b1;
    v.new_address       = sh_proxy_addr;
    v.new_port          = sh_proxy_port;
    v.target_process    = sh_proxy_proc;
    v.original_address  = rule_row[hit].address;
    v.original_port     = c.port;
    v.original_protocol = c.protocol;
    v.original_process  = c.origin_process;
    return v;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
  endtask

  task automatic check_verdict(verdict_t w);
    if (out_bus.action !== w.action)
      flag_mismatch("action", out_bus.action, w.action);
    if (out_bus.redirected !== w.redirected)
      flag_mismatch("redirected", out_bus.redirected, w.redirected);
    if (out_bus.new_address !== w.new_address)
      flag_mismatch("new_address", out_bus.new_address, w.new_address);
    if (out_bus.new_port !== w.new_port)
      flag_mismatch("new_port", out_bus.new_port, w.new_port);
    if (out_bus.target_process !== w.target_process)
      flag_mismatch("target_process", out_bus.target_process, w.target_process);
    if (out_bus.original_address !== w.original_address)
      flag_mismatch("original_address", out_bus.original_address, w.original_address);
    if (out_bus.original_port !== w.original_port)
      flag_mismatch("original_port", out_bus.original_port, w.original_port);
    if (out_bus.original_protocol !== w.original_protocol)
      flag_mismatch("original_protocol", out_bus.original_protocol, w.original_protocol);
    if (out_bus.original_process !== w.original_process)
      flag_mismatch("original_process", out_bus.original_process, w.original_process);
  endtask

  // input driver: predict on acceptance, then hold, idle or present the next beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (cur_beat.func == FUNC_WRITE) begin
          rule_row[cur_beat.rule_slot] <= {cur_beat.protocol, cur_beat.address, cur_beat.port};
          n_writes++;
        end else begin
          verdicts_due.push_back(classify_conn(cur_beat));
          n_classify++;
        end
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (beats_pending.size() > 0) begin
          cur_beat = beats_pending.pop_front();
          in_bus.func               <= cur_beat.func;
          in_bus.rule_slot          <= cur_beat.rule_slot;
          in_bus.protocol           <= cur_beat.protocol;
          in_bus.address            <= cur_beat.address;
          in_bus.port               <= cur_beat.port;
          in_bus.origin_process     <= cur_beat.origin_process;
          in_bus.write_right        <= cur_beat.write_right;
          in_bus.already_redirected <= cur_beat.already_redirected;
          in_bus.redirect_possible  <= cur_beat.redirect_possible;
          in_bus.valid <= 1'b1;
          send_gap = no_idle ? 0 : pick_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor with random back-pressure
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch("verdict with none due", {30'd0, out_bus.action}, 32'd0);
        end else begin
          want = verdicts_due.pop_front();
          check_verdict(want);
          case (want.action)
            ACT_NONE:  n_none++;
            ACT_BLOCK: n_block++;
            default: begin
              if (want.redirected) n_redirect++;
              else n_permit++;
            end
          endcase
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        recv_stall = no_idle ? 0 : pick_gap();
      end
    end
  end

  task automatic cfg_write(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (r)
      REG_PROXY_ADDR:   sh_proxy_addr   = v;
      REG_PROXY_PORT:   sh_proxy_port   = v[15:0];
      REG_PROXY_PROC:   sh_proxy_proc   = v;
      REG_FAIL_CLOSED:  sh_fail_closed  = v[0];
      REG_ACTIVE_RULES: sh_active_rules = v[8:0];
      REG_REDIRECT_EN:  sh_redirect_en  = v[0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [31:0] paddr_v, logic [15:0] pport, logic [31:0] pproc,
                         logic fc, logic [31:0] active, logic en);
    cfg_write(REG_PROXY_ADDR, paddr_v);
    cfg_write(REG_PROXY_PORT, {16'd0, pport});
    cfg_write(REG_PROXY_PROC, pproc);
    cfg_write(REG_FAIL_CLOSED, {31'd0, fc});
    cfg_write(REG_ACTIVE_RULES, active);
    cfg_write(REG_REDIRECT_EN, {31'd0, en});
  endtask

  // drain: every beat accepted, every verdict seen, then let a rule write settle
  task automatic wait_idle();
    do @(posedge clk); while (beats_pending.size() != 0 || in_bus.valid);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] a_any, b_p80, c_top, d_udp;
    logic [31:0] pa, pp;
    logic [8:0]  ar;
    int          i, p, n, r;

    no_idle = 1'b0;
    sh_proxy_addr = '0; sh_proxy_port = '0; sh_proxy_proc = '0;
    sh_fail_closed = 1'b0; sh_active_rules = '0; sh_redirect_en = 1'b0;
    rst_n       <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    addr_pool[0] = 32'd0;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = LOOPBACK_ADDR;
    for (i = 3; i < 8; i++) addr_pool[i] = $urandom;
    port_pool[0] = 16'd0;
    port_pool[1] = 16'd80;
    port_pool[2] = 16'd443;
    port_pool[3] = 16'hFFFF;
    port_pool[4] = 16'($urandom);
    port_pool[5] = 16'($urandom);
    a_any = 32'hC0A8_0101;
    b_p80 = 32'h0A00_0002;
    c_top = 32'h0808_0808;
    d_udp = 32'hAC10_0001;

    // load every slot before the first search touches the table
    for (i = 0; i < MAX_RULES; i++) beats_pending.push_back(random_rule_write(8'(i)));

    // reset settings: no write right, then redirection off
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF,
                                      32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 8'h00, PROTO_TCP, addr_pool[3], 16'd80,
                                      32'd1, 1'b1, 1'b0, 1'b1));
    wait_idle();

    cfg_all(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd256, 1'b1);
    beats_pending.push_back(make_item(FUNC_WRITE, 8'd0, PROTO_TCP, a_any, 16'd0, 0, 0, 0, 0));
    beats_pending.push_back(make_item(FUNC_WRITE, 8'd1, PROTO_TCP, b_p80, 16'd80, 0, 0, 0, 0));
    beats_pending.push_back(make_item(FUNC_WRITE, 8'd2, PROTO_TCP, LOOPBACK_ADDR, 16'd0,
                                      0, 0, 0, 0));
    beats_pending.push_back(make_item(FUNC_WRITE, 8'd3, 8'd17, d_udp, 16'd0, 0, 0, 0, 0));
    beats_pending.push_back(make_item(FUNC_WRITE, 8'd255, PROTO_TCP, c_top, 16'hFFFF,
                                      0, 0, 0, 0));
    // any-port rule, exact port hit and miss, loopback, last slot, non-TCP
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, a_any, 16'h1234,
                                      32'd0, 1'b1, 1'b0, 1'b1));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, b_p80, 16'd80,
                                      32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, b_p80, 16'd81,
                                      32'd5, 1'b1, 1'b0, 1'b1));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, LOOPBACK_ADDR, 16'd22,
                                      32'd5, 1'b1, 1'b0, 1'b1));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, c_top, 16'hFFFF,
                                      32'h8000_0001, 1'b1, 1'b0, 1'b1));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, 8'd17, d_udp, 16'd53,
                                      32'd7, 1'b1, 1'b0, 1'b1));
    // already redirected, redirect impossible (fail closed), no write right, no rule match
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, a_any, 16'd443,
                                      32'd9, 1'b1, 1'b1, 1'b1));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, a_any, 16'd443,
                                      32'd9, 1'b1, 1'b0, 1'b0));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, a_any, 16'd443,
                                      32'd9, 1'b0, 1'b0, 1'b1));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, 32'h0102_0304, 16'd443,
                                      32'd9, 1'b1, 1'b0, 1'b1));
    wait_idle();

    // last slot out of the searched range; fail open
    cfg_all(32'd0, 16'd0, 32'd0, 1'b0, 32'd255, 1'b1);
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, c_top, 16'hFFFF,
                                      32'd3, 1'b1, 1'b0, 1'b1));
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, a_any, 16'd1,
                                      32'd3, 1'b1, 1'b0, 1'b0));
    wait_idle();
    cfg_write(REG_ACTIVE_RULES, 32'd0);
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, a_any, 16'd1,
                                      32'd3, 1'b1, 1'b0, 1'b1));
    wait_idle();
    // oversized rule count saturates to the full table
    cfg_write(REG_ACTIVE_RULES, 32'hFFFF_FFFF);
    beats_pending.push_back(make_item(FUNC_CLASSIFY, 0, PROTO_TCP, c_top, 16'hFFFF,
                                      32'd3, 1'b1, 1'b0, 1'b1));
    wait_idle();

    for (p = 0; p < 6; p++) begin
      case (p)
        0:       ar = 9'd256;
        1:       ar = 9'd1;
        2:       ar = 9'($urandom_range(2, 255));
        3:       ar = 9'($urandom_range(257, 511));
        4:       ar = 9'($urandom_range(0, 511));
        default: ar = 9'd256;
      endcase
      pa = (p == 0) ? 32'd0 : (p == 1) ? 32'hFFFF_FFFF : $urandom;
      pp = (p == 0) ? 32'd0 : (p == 1) ? 32'hFFFF_FFFF : $urandom;
      cfg_all(pa, pp[15:0], (p == 1) ? 32'hFFFF_FFFF : $urandom, p[0], {23'd0, ar}, p != 4);
      no_idle = (p == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 18)
          beats_pending.push_back(random_rule_write(($urandom_range(0, 99) < 60)
                                                    ? 8'($urandom_range(0, 15))
                                                    : 8'($urandom)));
        else if (r < 90)
          beats_pending.push_back(random_conn());
        else
          beats_pending.push_back(make_item(1'($urandom), 8'($urandom), 8'($urandom),
                                            $urandom, 16'($urandom), $urandom, 1'($urandom),
                                            1'($urandom), 1'($urandom)));
      end
      wait_idle();
    end
    no_idle = 1'b0;
    repeat (MAX_RULES + 8) @(posedge clk);

    $display("rule writes %0d, classify beats %0d over 11 register settings",
             n_writes, n_classify);
    $display("verdicts: %0d redirected, %0d permitted, %0d blocked, %0d without action",
             n_redirect, n_permit, n_block, n_none);
    if (errors == 0) begin
      $display("[connection_redirect_rule_classifier_top] OK");
    end else begin
      $display("mismatches: %0d", errors);
      $display("[connection_redirect_rule_classifier_top] ERROR");
    end
    $finish;
  end

endmodule
